@@ src/closed_catmull_rom_evaluator_core_assert.svh @@
// assertion macros for the catmull-rom evaluator core
// expects aclk and aresetn in the scope where a macro is used
`ifndef CLOSED_CATMULL_ROM_EVALUATOR_CORE_ASSERT_SVH
`define CLOSED_CATMULL_ROM_EVALUATOR_CORE_ASSERT_SVH

// same-cycle implication
`define CCR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ccr_pkg.sv @@
// shared types, constants and arithmetic helpers for the catmull-rom core
// no dependencies
package ccr_pkg;

    localparam int COORD_W   = 32;
    localparam int COUNT_W   = 7;
    localparam int INDEX_W   = 6;
    localparam int TIME_BITS = 16;
    localparam int ACC_W     = 40;
    localparam int PROD_W    = ACC_W + TIME_BITS + 1;

    // transaction modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic [TIME_BITS-1:0]      frac_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // per-stage load enables for the lane datapath
    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
        logic s6;
        logic so;
    } stage_en_t;

    localparam acc_t SAT_MAX = acc_t'(64'sd2147483647);
    localparam acc_t SAT_MIN = acc_t'(-64'sd2147483648);

    // floor((a * u + 2^15) / 2^16)
    function automatic acc_t round_mul(acc_t a, frac_t u);
        logic signed [PROD_W-1:0] p;
        p = a * $signed({1'b0, u});
        p = p + $signed(PROD_W'(1) << (TIME_BITS - 1));
        return acc_t'(p >>> TIME_BITS);
    endfunction

    // floor((v + 1) / 2), then clamp to 32 bits
    function automatic coord_t sat_half(acc_t v);
        acc_t r;
        r = (v + acc_t'(1)) >>> 1;
        if (r > SAT_MAX) begin
            return coord_t'(SAT_MAX);
        end else if (r < SAT_MIN) begin
            return coord_t'(SAT_MIN);
        end
        return coord_t'(r);
    endfunction

endpackage

@@ src/closed_catmull_rom_evaluator_core.sv @@
// top level of the closed-loop catmull-rom evaluator
// depends on ccr_pkg, ccr_point_store, ccr_axis_lane and the assertion header
`include "closed_catmull_rom_evaluator_core_assert.svh"

// Evaluates a closed uniform Catmull-Rom loop of up to MAX_POINTS 3D points
// in signed Q16.16. A transaction with mode 0 stores one point, mode 1 maps
// eval_time (Q0.16) onto as many segments as the configured loop length and
// returns position and derivative per local t, both saturated to 32 bits.
// The core is a seven stage pipeline (segment scale, point read, basis,
// three horner steps, output register) and takes one transaction per cycle
// while no stage is stalled; m_valid rises once an evaluate transaction has
// passed the stage registers into the output register, with stalls absorbed
// stage by stage. Point reads come from two replicated memories with
// two read ports each. Points must be written before they are evaluated.
module closed_catmull_rom_evaluator_core #(
    parameter int MAX_POINTS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ccr_pkg::COUNT_W-1:0]       cfg_loop_len,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [ccr_pkg::INDEX_W-1:0]       s_point_index,
    input  logic signed [ccr_pkg::COORD_W-1:0] s_coord_x,
    input  logic signed [ccr_pkg::COORD_W-1:0] s_coord_y,
    input  logic signed [ccr_pkg::COORD_W-1:0] s_coord_z,
    input  logic [ccr_pkg::TIME_BITS-1:0]     s_eval_time,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [ccr_pkg::COORD_W-1:0] m_pos_x,
    output logic signed [ccr_pkg::COORD_W-1:0] m_pos_y,
    output logic signed [ccr_pkg::COORD_W-1:0] m_pos_z,
    output logic signed [ccr_pkg::COORD_W-1:0] m_tangent_x,
    output logic signed [ccr_pkg::COORD_W-1:0] m_tangent_y,
    output logic signed [ccr_pkg::COORD_W-1:0] m_tangent_z
);

    localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW     = $clog2(MAX_POINTS + 1);
    localparam int CCW    = (CW > ccr_pkg::COUNT_W) ? CW : ccr_pkg::COUNT_W;
    localparam int SCALEW = ccr_pkg::TIME_BITS + CW;

    logic [ccr_pkg::COUNT_W-1:0] count_reg;
    logic [CCW-1:0]    count_ext;
    logic [CW-1:0]     n_eff;
    logic [SCALEW-1:0] scaled;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, vo_reg;
    logic rdy2, rdy3, rdy4, rdy5, rdy6, rdyo;

    logic              mode1_reg, wok1_reg;
    logic [AW-1:0]     addr1_reg, seg1_reg;
    ccr_pkg::point_t   pt1_reg;
    ccr_pkg::frac_t    u1_reg, u2_reg;

    logic [AW-1:0]     last_idx, idx0, idx1, idx2, idx3;
    ccr_pkg::point_t   rp0, rp1, rp2, rp3;
    ccr_pkg::stage_en_t en;
    logic              store_wr;

    // loop length register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= ccr_pkg::COUNT_W'(4);
        end else if (cfg_valid) begin
            count_reg <= cfg_loop_len;
        end
    end

    // effective count clamped to one..MAX_POINTS
    always_comb begin
        count_ext = CCW'(count_reg);
        if (count_reg == '0) begin
            n_eff = CW'(1);
        end else if (count_ext > CCW'(MAX_POINTS)) begin
            n_eff = CW'(MAX_POINTS);
        end else begin
            n_eff = CW'(count_ext);
        end
        scaled = SCALEW'(s_eval_time) * SCALEW'(n_eff);
    end

    // stage ready chain
    assign rdyo    = !vo_reg || m_ready;
    assign rdy6    = !v6_reg || rdyo;
    assign rdy5    = !v5_reg || rdy6;
    assign rdy4    = !v4_reg || rdy5;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign s_ready = !v1_reg || rdy2;

    assign en.s3 = rdy3;
    assign en.s4 = rdy4;
    assign en.s5 = rdy5;
    assign en.s6 = rdy6;
    assign en.so = rdyo;

    // valid bits; loads leave after stage one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (s_ready) v1_reg <= s_valid;
            if (rdy2)    v2_reg <= v1_reg && (mode1_reg == ccr_pkg::MODE_EVAL);
            if (rdy3)    v3_reg <= v2_reg;
            if (rdy4)    v4_reg <= v3_reg;
            if (rdy5)    v5_reg <= v4_reg;
            if (rdy6)    v6_reg <= v5_reg;
            if (rdyo)    vo_reg <= v6_reg;
        end
    end

    // stage one: segment and local t
    always_ff @(posedge aclk) begin
        if (s_ready) begin
            mode1_reg <= s_mode;
            wok1_reg  <= 32'(s_point_index) < MAX_POINTS;
            addr1_reg <= AW'(s_point_index);
            pt1_reg   <= '{x: s_coord_x, y: s_coord_y, z: s_coord_z};
            seg1_reg  <= scaled[ccr_pkg::TIME_BITS +: AW];
            u1_reg    <= scaled[ccr_pkg::TIME_BITS-1:0];
        end
    end

    // neighbor indices modulo the count
    always_comb begin
        last_idx = AW'(n_eff - CW'(1));
        idx1     = seg1_reg;
        idx0     = (seg1_reg == '0) ? last_idx : seg1_reg - AW'(1);
        idx2     = (seg1_reg == last_idx) ? '0 : seg1_reg + AW'(1);
        idx3     = (idx2 == last_idx) ? '0 : idx2 + AW'(1);
    end

    assign store_wr = v1_reg && (mode1_reg == ccr_pkg::MODE_LOAD) && wok1_reg && rdy2;

    ccr_point_store #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW)
    ) u_store (
        .aclk     (aclk),
        .wr_en    (store_wr),
        .wr_addr  (addr1_reg),
        .wr_data  (pt1_reg),
        .rd_en    (rdy2),
        .rd_addr0 (idx0),
        .rd_addr1 (idx1),
        .rd_addr2 (idx2),
        .rd_addr3 (idx3),
        .rd_data0 (rp0),
        .rd_data1 (rp1),
        .rd_data2 (rp2),
        .rd_data3 (rp3)
    );

    // local t travels beside the read data
    always_ff @(posedge aclk) begin
        if (rdy2) begin
            u2_reg <= u1_reg;
        end
    end

    ccr_axis_lane u_lane_x (
        .aclk (aclk), .en (en),
        .p0 (rp0.x), .p1 (rp1.x), .p2 (rp2.x), .p3 (rp3.x),
        .u_in (u2_reg), .pos (m_pos_x), .tangent (m_tangent_x)
    );

    ccr_axis_lane u_lane_y (
        .aclk (aclk), .en (en),
        .p0 (rp0.y), .p1 (rp1.y), .p2 (rp2.y), .p3 (rp3.y),
        .u_in (u2_reg), .pos (m_pos_y), .tangent (m_tangent_y)
    );

    ccr_axis_lane u_lane_z (
        .aclk (aclk), .en (en),
        .p0 (rp0.z), .p1 (rp1.z), .p2 (rp2.z), .p3 (rp3.z),
        .u_in (u2_reg), .pos (m_pos_z), .tangent (m_tangent_z)
    );

    assign m_valid = vo_reg;

    // checks
    `CCR_ASSERT_NEXT(a_load_leaves, store_wr, !v2_reg, "load reached stage two")
    `CCR_ASSERT_NEXT(a_stall_keeps, v5_reg && !rdy6, v5_reg, "stalled item lost in stage five")
    `CCR_ASSERT_NOW(a_count_range, 1'b1, n_eff != '0 && n_eff <= CW'(MAX_POINTS), "bad count")
    `CCR_ASSERT_NOW(a_seg_range, v1_reg && mode1_reg, seg1_reg <= last_idx, "segment out of range")

endmodule

@@ src/ccr_point_store.sv @@
// control point memory, two copies with two read ports each
// depends on ccr_pkg
module ccr_point_store #(
    parameter int MAX_POINTS = 64,
    parameter int AW         = 6
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  ccr_pkg::point_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr0,
    input  logic [AW-1:0]   rd_addr1,
    input  logic [AW-1:0]   rd_addr2,
    input  logic [AW-1:0]   rd_addr3,
    output ccr_pkg::point_t rd_data0,
    output ccr_pkg::point_t rd_data1,
    output ccr_pkg::point_t rd_data2,
    output ccr_pkg::point_t rd_data3
);

    ccr_pkg::point_t bank_a [MAX_POINTS];
    ccr_pkg::point_t bank_b [MAX_POINTS];

    // both copies take every write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            bank_a[wr_addr] <= wr_data;
            bank_b[wr_addr] <= wr_data;
        end
    end

    // registered reads, held while the stage stalls
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data0 <= bank_a[rd_addr0];
            rd_data1 <= bank_a[rd_addr1];
            rd_data2 <= bank_b[rd_addr2];
            rd_data3 <= bank_b[rd_addr3];
        end
    end

endmodule

@@ src/ccr_axis_lane.sv @@
// one axis of the spline datapath: basis, horner steps, rounding, saturation
// depends on ccr_pkg
module ccr_axis_lane (
    input  logic                aclk,
    input  ccr_pkg::stage_en_t  en,
    input  ccr_pkg::coord_t     p0,
    input  ccr_pkg::coord_t     p1,
    input  ccr_pkg::coord_t     p2,
    input  ccr_pkg::coord_t     p3,
    input  ccr_pkg::frac_t      u_in,
    output ccr_pkg::coord_t     pos,
    output ccr_pkg::coord_t     tangent
);

    ccr_pkg::acc_t  e0, e1, e2, e3;
    ccr_pkg::acc_t  b3_next, b2_next, b1_next, b0_next;
    ccr_pkg::acc_t  b3_reg, b2_reg, b1_reg, b0_reg;
    ccr_pkg::frac_t u3_reg, u4_reg, u5_reg;
    ccr_pkg::acc_t  b1_4_reg, b0_4_reg, b0_5_reg;
    ccr_pkg::acc_t  h1_reg, g1_reg, h2_reg, g2_reg, h3_reg;
    ccr_pkg::coord_t tan6_reg, pos_reg, tan_reg;

    // doubled basis coefficients
    always_comb begin
        e0 = ccr_pkg::acc_t'(p0);
        e1 = ccr_pkg::acc_t'(p1);
        e2 = ccr_pkg::acc_t'(p2);
        e3 = ccr_pkg::acc_t'(p3);
        b3_next = e3 - e0 + (e1 + (e1 <<< 1)) - (e2 + (e2 <<< 1));
        b2_next = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
        b1_next = e2 - e0;
        b0_next = e1 <<< 1;
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            b3_reg <= b3_next;
            b2_reg <= b2_next;
            b1_reg <= b1_next;
            b0_reg <= b0_next;
            u3_reg <= u_in;
        end
    end

    // first horner step
    always_ff @(posedge aclk) begin
        if (en.s4) begin
            h1_reg   <= b2_reg + ccr_pkg::round_mul(b3_reg, u3_reg);
            g1_reg   <= (b2_reg <<< 1)
                        + ccr_pkg::round_mul(b3_reg + (b3_reg <<< 1), u3_reg);
            b1_4_reg <= b1_reg;
            b0_4_reg <= b0_reg;
            u4_reg   <= u3_reg;
        end
    end

    // second horner step
    always_ff @(posedge aclk) begin
        if (en.s5) begin
            h2_reg   <= b1_4_reg + ccr_pkg::round_mul(h1_reg, u4_reg);
            g2_reg   <= b1_4_reg + ccr_pkg::round_mul(g1_reg, u4_reg);
            b0_5_reg <= b0_4_reg;
            u5_reg   <= u4_reg;
        end
    end

    // last position step, derivative finishes
    always_ff @(posedge aclk) begin
        if (en.s6) begin
            h3_reg   <= b0_5_reg + ccr_pkg::round_mul(h2_reg, u5_reg);
            tan6_reg <= ccr_pkg::sat_half(g2_reg);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (en.so) begin
            pos_reg <= ccr_pkg::sat_half(h3_reg);
            tan_reg <= tan6_reg;
        end
    end

    assign pos     = pos_reg;
    assign tangent = tan_reg;

endmodule

@@ test/ccr_scoreboard.sv @@
`timescale 1ns / 100ps
// result checker for the closed-loop catmull-rom core: keeps its own point store
// and loop size, predicts each evaluate transaction and compares the results; uses ccr_pkg
module ccr_scoreboard (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [ccr_pkg::COUNT_W-1:0]   cfg_loop_len,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_mode,
    input  logic [ccr_pkg::INDEX_W-1:0]   s_point_index,
    input  ccr_pkg::coord_t               s_coord_x,
    input  ccr_pkg::coord_t               s_coord_y,
    input  ccr_pkg::coord_t               s_coord_z,
    input  ccr_pkg::frac_t                s_eval_time,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  ccr_pkg::coord_t               m_pos_x,
    input  ccr_pkg::coord_t               m_pos_y,
    input  ccr_pkg::coord_t               m_pos_z,
    input  ccr_pkg::coord_t               m_tangent_x,
    input  ccr_pkg::coord_t               m_tangent_y,
    input  ccr_pkg::coord_t               m_tangent_z,
    output int                            mismatches,
    output int                            pending
);

    localparam int SLOTS = 64;

    typedef struct {
        ccr_pkg::coord_t pos [3];
        ccr_pkg::coord_t tan [3];
    } curve_sample_t;

    ccr_pkg::coord_t pts [3][SLOTS];
    logic [ccr_pkg::COUNT_W-1:0] loop_size;
    curve_sample_t samples_due [$];

    initial begin
        mismatches = 0;
        pending = 0;
    end

    // floor((v + 2^(sh-1)) / 2^sh)
    function automatic longint round_down(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic ccr_pkg::coord_t clamp32(longint v);
        if (v > 64'sd2147483647) return ccr_pkg::coord_t'(32'h7fffffff);
        if (v < -64'sd2147483648) return ccr_pkg::coord_t'(32'h80000000);
        return ccr_pkg::coord_t'(v);
    endfunction

    // one axis of the uniform basis, position and derivative per local t
    task automatic spline_axis(input ccr_pkg::coord_t c0, input ccr_pkg::coord_t c1,
                               input ccr_pkg::coord_t c2, input ccr_pkg::coord_t c3,
                               input longint u,
                               output ccr_pkg::coord_t pos, output ccr_pkg::coord_t tan);
        longint p0, p1, p2, p3, b0, b1, b2, b3, h, g;
        p0 = c0; p1 = c1; p2 = c2; p3 = c3;
        b3 = -p0 + 3 * p1 - 3 * p2 + p3;
        b2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        b1 = p2 - p0;
        b0 = 2 * p1;
        h = b2 + round_down(b3 * u, ccr_pkg::TIME_BITS);
        h = b1 + round_down(h * u, ccr_pkg::TIME_BITS);
        h = b0 + round_down(h * u, ccr_pkg::TIME_BITS);
        pos = clamp32(round_down(h, 1));
        g = 2 * b2 + round_down(3 * b3 * u, ccr_pkg::TIME_BITS);
        g = b1 + round_down(g * u, ccr_pkg::TIME_BITS);
        tan = clamp32(round_down(g, 1));
    endtask

    task automatic predict_sample(input ccr_pkg::frac_t t);
        int n, seg, i0, a;
        longint scaled, u;
        curve_sample_t smp;
        n = loop_size;
        if (n == 0) n = 1;
        if (n > SLOTS) n = SLOTS;
        scaled = longint'(t) * n;
        seg = int'(scaled >>> ccr_pkg::TIME_BITS) % n;
        u = scaled & 64'hffff;
        i0 = (seg + n - 1) % n;
        for (a = 0; a < 3; a++) begin
            spline_axis(pts[a][i0], pts[a][(i0 + 1) % n], pts[a][(i0 + 2) % n],
                        pts[a][(i0 + 3) % n], u, smp.pos[a], smp.tan[a]);
        end
        samples_due.push_back(smp);
    endtask

    task automatic compare_sample();
        curve_sample_t want;
        ccr_pkg::coord_t got_pos [3];
        ccr_pkg::coord_t got_tan [3];
        bit bad;
        int a;
        got_pos = '{m_pos_x, m_pos_y, m_pos_z};
        got_tan = '{m_tangent_x, m_tangent_y, m_tangent_z};
        if (samples_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result transaction at %0t", $realtime);
        end else begin
            want = samples_due.pop_front();
            bad = 0;
            for (a = 0; a < 3; a++)
                if (want.pos[a] !== got_pos[a] || want.tan[a] !== got_tan[a]) bad = 1;
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at %0t", $realtime);
                    for (a = 0; a < 3; a++)
                        $display("  axis %0d pos exp %0d got %0d  tan exp %0d got %0d", a,
                                 want.pos[a], got_pos[a], want.tan[a], got_tan[a]);
                end
            end
        end
    endtask

    // track every transaction on the three channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            loop_size = 7'd4;
            samples_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) loop_size = cfg_loop_len;
            if (m_valid && m_ready) compare_sample();
            if (s_valid && s_ready) begin
                if (s_mode == ccr_pkg::MODE_EVAL) begin
                    predict_sample(s_eval_time);
                end else begin
                    pts[0][s_point_index] = s_coord_x;
                    pts[1][s_point_index] = s_coord_y;
                    pts[2][s_point_index] = s_coord_z;
                end
            end
        end
        pending = samples_due.size();
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// stimulus and verdict for closed_catmull_rom_evaluator_core
// depends on ccr_pkg, the core and ccr_scoreboard
module testbench;

    localparam int SETTLE = 12;
    localparam int STALL_LIMIT = 5000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ccr_pkg::COUNT_W-1:0] cfg_loop_len = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_mode = 1'b0;
    logic [ccr_pkg::INDEX_W-1:0] s_point_index = '0;
    ccr_pkg::coord_t s_coord_x = '0, s_coord_y = '0, s_coord_z = '0;
    ccr_pkg::frac_t s_eval_time = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ccr_pkg::coord_t m_pos_x, m_pos_y, m_pos_z, m_tangent_x, m_tangent_y, m_tangent_z;
    int mismatches, pending;

    bit src_idle = 1;
    bit sink_idle = 1;
    bit [63:0] loaded = '0;
    int stall_cycles = 0;

    always #4 aclk = ~aclk;

    closed_catmull_rom_evaluator_core dut (.*);

    ccr_scoreboard checker_i (.*);

    // result side back-pressure
    always @(posedge aclk)
        m_ready <= !sink_idle || ($urandom_range(99) >= 17);

    // watchdog on cycles with no transaction at all
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_item(input bit mode, input logic [ccr_pkg::INDEX_W-1:0] idx,
                             input ccr_pkg::coord_t x, input ccr_pkg::coord_t y,
                             input ccr_pkg::coord_t z, input ccr_pkg::frac_t t);
        if (src_idle && $urandom_range(99) < 17) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < 17) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_point_index <= idx;
        s_coord_x <= x;
        s_coord_y <= y;
        s_coord_z <= z;
        s_eval_time <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (mode == ccr_pkg::MODE_LOAD) loaded[idx] = 1'b1;
    endtask

    function automatic ccr_pkg::coord_t rand_coord();
        case ($urandom_range(5))
            0: return ccr_pkg::coord_t'(32'h7fffffff);
            1: return ccr_pkg::coord_t'(32'h80000000);
            2: return ccr_pkg::coord_t'($urandom_range(131072) - 65536);
            3: return ccr_pkg::coord_t'($urandom_range(1 << 24) - (1 << 23));
            default: return ccr_pkg::coord_t'($urandom);
        endcase
    endfunction

    function automatic ccr_pkg::frac_t rand_time();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hffff;
            default: return ccr_pkg::frac_t'($urandom);
        endcase
    endfunction

    task automatic load_random(input int idx);
        send_item(ccr_pkg::MODE_LOAD, ccr_pkg::INDEX_W'(idx), rand_coord(), rand_coord(),
                  rand_coord(), '0);
    endtask

    // drain, let trailing loads settle, then write the loop size
    task automatic set_loop_size(input logic [ccr_pkg::COUNT_W-1:0] value);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_loop_len <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // every slot the loop can reach must hold a written point
    task automatic fill_reachable(input int size);
        int n, i;
        n = (size == 0) ? 1 : (size > 64 ? 64 : size);
        for (i = 0; i < n; i++)
            if (!loaded[i]) load_random(i);
    endtask

    task automatic random_phase(input logic [ccr_pkg::COUNT_W-1:0] size, input int items);
        int k;
        set_loop_size(size);
        fill_reachable(size);
        for (k = 0; k < items; k++) begin
            if ($urandom_range(99) < 70)
                send_item(ccr_pkg::MODE_EVAL, ccr_pkg::INDEX_W'($urandom), rand_coord(),
                          rand_coord(), rand_coord(), rand_time());
            else
                load_random($urandom_range(63));
        end
    endtask

    initial begin
        logic [ccr_pkg::COUNT_W-1:0] sizes [8];
        int p;
        sizes = '{7'd1, 7'd0, 7'd64, 7'd127, 7'd2, 7'd65, 7'd3, 7'd4};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extreme points on the reset loop of four
        send_item(ccr_pkg::MODE_LOAD, 6'd0, 32'h7fffffff, 32'h80000000, 32'h00010000, '0);
        send_item(ccr_pkg::MODE_LOAD, 6'd1, 32'h80000000, 32'h7fffffff, 32'hffff0000, '0);
        send_item(ccr_pkg::MODE_LOAD, 6'd2, 32'h7fffffff, 32'h80000000, 32'h00000000, '0);
        send_item(ccr_pkg::MODE_LOAD, 6'd3, 32'h80000000, 32'h7fffffff, 32'hffffffff, '0);
        send_item(ccr_pkg::MODE_EVAL, 6'd63, '0, '0, '0, 16'h0000);
        send_item(ccr_pkg::MODE_EVAL, 6'd0, '0, '0, '0, 16'hffff);
        send_item(ccr_pkg::MODE_EVAL, 6'd0, '0, '0, '0, 16'h8000);
        send_item(ccr_pkg::MODE_EVAL, 6'd0, '0, '0, '0, 16'h3fff);
        send_item(ccr_pkg::MODE_EVAL, 6'd0, '0, '0, '0, 16'h0001);
        send_item(ccr_pkg::MODE_LOAD, 6'd63, 32'h00010000, 32'h00020000, 32'hfffe0000, '0);
        // directed: single-point loop, zero and oversize counts
        set_loop_size(7'd1);
        send_item(ccr_pkg::MODE_EVAL, 6'd0, '0, '0, '0, 16'h7777);
        set_loop_size(7'd0);
        send_item(ccr_pkg::MODE_EVAL, 6'd0, '0, '0, '0, 16'hffff);
        set_loop_size(7'd127);
        fill_reachable(127);
        send_item(ccr_pkg::MODE_EVAL, 6'd0, '0, '0, '0, 16'hffff);
        send_item(ccr_pkg::MODE_EVAL, 6'd0, '0, '0, '0, 16'h0000);

        // random phases, one of them without any idling
        for (p = 0; p < 12; p++) begin
            src_idle = (p != 2);
            sink_idle = (p != 2);
            random_phase(p < 8 ? sizes[p] : ccr_pkg::COUNT_W'($urandom_range(1, 127)), 115);
        end
        src_idle = 1;
        sink_idle = 1;

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
